@@ rtl/ntt_pkg.sv @@
package ntt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int CNT_MAX_W       = 8;

  localparam int NODE_W   = 8;
  localparam int TIME_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 8;

  localparam logic [TIME_W-1:0] EXPIRY_RESET = 64'd300000;

  localparam logic OP_ATTEST = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_VERIFY_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EVAL = 3'b100
  } state_t;

  typedef struct packed {
    logic zero;
    logic over;
  } alu_flags_t;

endpackage

@@ rtl/node_trust_table_core.sv @@
// channel  dir  signals                      payload
// s        in   s_tvalid s_tready s_tdata    s_tuser: opcode; s_tdata: node_id, verify_ok, now_ms
//                s_tuser
// m        out  m_tvalid m_tready m_tdata    status, trusted, num_entries
// cfg      in   cfg_valid cfg_ready cfg_data expiry_time
//
// One item passes through accept, up to one table read per entry through a
// single shared subtract/compare unit, and an evaluate step that writes back
// and loads the output register.
// Reset (rst, synchronous) empties the table and restores expiry_time.
// A result held in the output register stalls the next item only at its
// final evaluate cycle.
module node_trust_table_core #(
  parameter int TABLE_DEPTH = ntt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ntt_pkg::IN_W-1:0]    s_tdata,   // node_id[7:0], verify_ok[8], now_ms[72:9]
  input  logic                        s_tuser,   // opcode[0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ntt_pkg::OUT_W-1:0]   m_tdata,   // status[1:0], trusted[2], num_entries[7:3]
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ntt_pkg::TIME_W-1:0]  cfg_data   // expiry_time[63:0]
);
  import ntt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  state_t              state;
  logic [TIME_W-1:0]   expiry;
  logic                op_q;
  logic [NODE_W-1:0]   node_q;
  logic                vok_q;
  logic [TIME_W-1:0]   now_q;
  logic [CNT_W-1:0]    used;
  logic [CNT_W-1:0]    issue_idx;
  logic                cmp_vld;
  logic [IDX_W-1:0]    cmp_idx;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [NODE_W-1:0]   rd_node;
  logic [TIME_W-1:0]   rd_stamp;
  logic [NODE_W-1:0]   mem_node  [TABLE_DEPTH];
  logic [TIME_W-1:0]   mem_stamp [TABLE_DEPTH];

  logic [TIME_W-1:0]   alu_a;
  logic [TIME_W-1:0]   alu_b;
  alu_flags_t          flags;
  logic                match;
  logic                issue;
  logic                out_free;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic                full;
  logic [CNT_W-1:0]    used_next;
  logic [STATUS_W-1:0] status_next;
  logic                trusted_next;
  logic [CNT_MAX_W-1:0] used_ext;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // shared unit: node compare while scanning, elapsed-time check at evaluate
  always_comb begin
    if (state == S_EVAL) begin
      alu_a = now_q;
      alu_b = rd_stamp;
    end else begin
      alu_a = TIME_W'(node_q);
      alu_b = TIME_W'(rd_node);
    end
  end

  ntt_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .lim   (expiry),
    .flags (flags)
  );

  assign match    = cmp_vld && flags.zero;
  assign issue    = !match && (issue_idx < used);
  assign out_free = !m_tvalid || m_tready;
  assign full     = (used >= DEPTH_C);

  always_comb begin
    status_next  = ST_OK;
    trusted_next = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = hit_idx;
    used_next    = used;
    if (op_q == OP_ATTEST) begin
      priority if (!vok_q) begin
        status_next = ST_VERIFY_FAIL;
      end else if (hit) begin
        wr_en = 1'b1;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        wr_en     = 1'b1;
        wr_idx    = used[IDX_W-1:0];
        used_next = used + 1'b1;
      end
    end else begin
      trusted_next = hit && ((now_q == '0) || (expiry == '0) || !flags.over);
    end
  end

  assign used_ext = CNT_MAX_W'(used_next);

  // table storage
  always_ff @(posedge clk) begin
    if (state == S_EVAL && out_free && wr_en) begin
      mem_node[wr_idx]  <= node_q;
      mem_stamp[wr_idx] <= now_q;
    end
    if (state == S_SCAN && issue) begin
      rd_node  <= mem_node[issue_idx[IDX_W-1:0]];
      rd_stamp <= mem_stamp[issue_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q   <= s_tuser;
      node_q <= s_tdata[NODE_W-1:0];
      vok_q  <= s_tdata[NODE_W];
      now_q  <= s_tdata[NODE_W+TIME_W:NODE_W+1];
    end
    if (state == S_SCAN) begin
      cmp_idx <= issue_idx[IDX_W-1:0];
      if (match) begin
        hit_idx <= cmp_idx;
      end
    end
    if (state == S_EVAL && out_free) begin
      m_tdata <= {used_ext[COUNT_W-1:0], trusted_next, status_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      expiry    <= EXPIRY_RESET;
      used      <= '0;
      issue_idx <= '0;
      cmp_vld   <= 1'b0;
      hit       <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        expiry <= cfg_data;
      end
      if (state == S_EVAL && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state     <= S_SCAN;
            issue_idx <= '0;
            cmp_vld   <= 1'b0;
            hit       <= 1'b0;
          end
        end
        S_SCAN: begin
          if (match) begin
            hit   <= 1'b1;
            state <= S_EVAL;
          end else if (issue) begin
            issue_idx <= issue_idx + 1'b1;
            cmp_vld   <= 1'b1;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (out_free) begin
            used  <= used_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state register not one-hot");

  a_used_bound: assert property (@(posedge clk) disable iff (rst) used <= DEPTH_C)
    else $error("entry count above table depth");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
      (!$past(rst) && (used != $past(used))) |-> (used == $past(used) + 1'b1))
    else $error("entry count moved by more than one");

  a_result_from_eval: assert property (@(posedge clk) disable iff (rst)
      (!$past(rst) && $rose(m_tvalid)) |-> ($past(state) == S_EVAL))
    else $error("result raised outside evaluate");

endmodule

@@ rtl/ntt_alu.sv @@
module ntt_alu (
  input  logic [ntt_pkg::TIME_W-1:0] a,
  input  logic [ntt_pkg::TIME_W-1:0] b,
  input  logic [ntt_pkg::TIME_W-1:0] lim,
  output ntt_pkg::alu_flags_t        flags
);
  import ntt_pkg::*;

  logic [TIME_W-1:0] diff;

  // wrapping difference, tested for zero and against the limit
  assign diff       = a - b;
  assign flags.zero = (diff == '0);
  assign flags.over = (diff > lim);

endmodule

@@ sim/node_trust_table_checker.sv @@
`timescale 1ns / 100ps
module node_trust_table_checker
  import ntt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,   // node_id, verify_ok, now_ms
  input  logic                s_tuser,   // opcode
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OUT_W-1:0]    m_tdata,   // status, trusted, num_entries
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [TIME_W-1:0]   cfg_data,  // expiry_time
  output int                  fail_count,
  output int                  open_replies,
  output int                  replies_done
);

  typedef struct packed {
    logic [COUNT_W-1:0]  num_entries;
    logic                trusted;
    logic [STATUS_W-1:0] status;
  } trust_reply_t;

  logic [NODE_W-1:0] slot_node     [TABLE_DEPTH];
  logic              slot_attested [TABLE_DEPTH];
  logic              slot_active   [TABLE_DEPTH];
  logic [TIME_W-1:0] slot_stamp    [TABLE_DEPTH];
  int                slots_used = 0;
  logic [TIME_W-1:0] expiry_lim = EXPIRY_RESET;
  trust_reply_t      pending_replies [$];
  int                mismatches = 0;
  int                replies = 0;

  // updates the shadow table and returns the reply the block owes
  function automatic trust_reply_t predict_reply(input logic op,
                                                 input logic [NODE_W-1:0] node,
                                                 input logic ok,
                                                 input logic [TIME_W-1:0] now);
    trust_reply_t r;
    int hit;
    int i;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    // first active match wins
    for (i = slots_used - 1; i >= 0; i--) begin
      if (slot_active[i] && slot_node[i] == node) hit = i;
    end
    if (op == OP_ATTEST) begin
      if (!ok) begin
        r.status = ST_VERIFY_FAIL;
      end else if (hit >= 0) begin
        slot_attested[hit] = 1'b1;
        slot_stamp[hit] = now;
      end else if (slots_used >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot_node[slots_used] = node;
        slot_attested[slots_used] = 1'b1;
        slot_active[slots_used] = 1'b1;
        slot_stamp[slots_used] = now;
        slots_used++;
      end
    end else if (hit >= 0 && slot_attested[hit]) begin
      elapsed = now - slot_stamp[hit];
      r.trusted = (now == '0) || (expiry_lim == '0) || (elapsed <= expiry_lim);
    end
    r.num_entries = slots_used[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    trust_reply_t want;
    trust_reply_t got;
    int i;
    if (rst) begin
      for (i = 0; i < TABLE_DEPTH; i++) begin
        slot_attested[i] = 1'b0;
        slot_active[i] = 1'b0;
      end
      slots_used = 0;
      expiry_lim = EXPIRY_RESET;
      pending_replies.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        replies++;
        if (pending_replies.size() == 0) begin
          $error("unexpected reply %h", m_tdata);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.trusted != want.trusted) begin
            $error("trusted: expected %0d, got %0d", want.trusted, got.trusted);
            mismatches++;
          end
          if (got.num_entries != want.num_entries) begin
            $error("num_entries: expected %0d, got %0d", want.num_entries, got.num_entries);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pending_replies.push_back(predict_reply(s_tuser, s_tdata[NODE_W-1:0], s_tdata[NODE_W],
                                                s_tdata[NODE_W+TIME_W:NODE_W+1]));
      end
      if (cfg_valid && cfg_ready) expiry_lim = cfg_data;
    end
    fail_count <= mismatches;
    open_replies <= pending_replies.size();
    replies_done <= replies;
  end

endmodule

@@ sim/node_trust_table_core_test.sv @@
`timescale 1ns / 100ps
module node_trust_table_core_test;
  import ntt_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASE_ITEMS = 90;
  localparam int POOL_SIZE   = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TIME_W-1:0] cfg_data = '0;

  int                fail_count;
  int                open_replies;
  int                replies_done;
  int                items_sent = 0;
  int                idle_cycles = 0;
  int                stall_left = 0;
  logic              steady = 1'b0;
  logic [NODE_W-1:0] node_pool [POOL_SIZE];
  logic [TIME_W-1:0] now_base = '0;
  logic [TIME_W-1:0] expiry_plan [6];

  node_trust_table_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  node_trust_table_checker trust_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .open_replies (open_replies),
    .replies_done (replies_done)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // reply backpressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 30) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input logic op, input logic [NODE_W-1:0] node, input logic ok,
                           input logic [TIME_W-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, now, ok, node};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_expiry(input logic [TIME_W-1:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (open_replies != 0);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly known nodes on a running clock, with some stray ids and times
  task automatic random_item();
    logic op;
    logic ok;
    logic [NODE_W-1:0] node;
    logic [TIME_W-1:0] now;
    int r;
    op = 1'($urandom_range(0, 1));
    ok = (op == OP_QUERY) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 99) < 75) node = node_pool[$urandom_range(0, POOL_SIZE - 1)];
    else node = NODE_W'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 8) begin
      now = '0;
    end else if (r < 16) begin
      now = {$urandom, $urandom};
    end else begin
      if ($urandom_range(0, 99) < 80) now_base += TIME_W'($urandom_range(0, 5000));
      else now_base += TIME_W'($urandom_range(0, 600000));
      now = now_base;
    end
    send_item(op, node, ok, now);
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) node_pool[i] = NODE_W'($urandom_range(0, 255));
    node_pool[0] = 8'h00;
    node_pool[1] = 8'hFF;
    node_pool[2] = 8'h5A;
    expiry_plan[0] = TIME_W'($urandom_range(1000, 20000));
    expiry_plan[1] = 64'd1;
    expiry_plan[2] = '1;
    expiry_plan[3] = '0;
    expiry_plan[4] = {$urandom, $urandom};
    expiry_plan[5] = EXPIRY_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, expiry at its reset value
    send_item(OP_QUERY,  8'h00, 1'b0, 64'd0);
    send_item(OP_ATTEST, 8'hFF, 1'b0, 64'd5);
    send_item(OP_ATTEST, 8'h00, 1'b1, 64'd1000);
    send_item(OP_ATTEST, 8'hFF, 1'b1, '1);
    send_item(OP_QUERY,  8'hFF, 1'b0, 64'd0);
    send_item(OP_QUERY,  8'h00, 1'b0, 64'd301000);
    send_item(OP_QUERY,  8'h00, 1'b0, 64'd301001);
    send_item(OP_QUERY,  8'hFF, 1'b0, 64'd5);
    send_item(OP_QUERY,  8'h00, 1'b1, 64'd1000);
    send_item(OP_QUERY,  8'hA5, 1'b1, 64'd1000);
    send_item(OP_ATTEST, 8'h00, 1'b1, 64'h8000_0000_0000_0000);
    send_item(OP_QUERY,  8'h00, 1'b0, 64'd1000);
    send_item(OP_ATTEST, 8'h00, 1'b0, 64'd2000);
    send_item(OP_QUERY,  8'h00, 1'b0, 64'h8000_0000_0000_0000);
    send_item(OP_ATTEST, 8'h5A, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OP_QUERY,  8'h5A, 1'b0, '1);
    send_item(OP_QUERY,  8'h5A, 1'b0, 64'h0000_0000_0004_93E0);

    // random phases, one expiry setting each; clock starts near wrap
    now_base = 64'hFFFF_FFFF_FFF0_0000;
    for (int p = 0; p < 6; p++) begin
      write_expiry(expiry_plan[p]);
      steady = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    do @(posedge clk); while (open_replies != 0);
    repeat (25) @(posedge clk);
    $display("Sent %0d attest/query items, checked %0d replies over six expiry settings",
             items_sent, replies_done);
    $display("(min, all-ones, zero, random), with time wraparound and a filling table.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ntt_pkg.sv
rtl/ntt_alu.sv
rtl/node_trust_table_core.sv
sim/node_trust_table_checker.sv
sim/node_trust_table_core_test.sv
